// ----- src/oisl_pkg.sv -----
// ----------------------------------------------------------------------------
// oisl_pkg
// Shared types and constants for the unit sphere lifting pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package oisl_pkg;

  // fixed point constants
  localparam logic [32:0] OneQ32  = 33'h1_0000_0000;
  localparam logic [17:0] XiReset = 18'd65536;
  localparam logic [33:0] OutMax  = 34'd131072;
  localparam logic [18:0] InvZ    = 19'd65536;

  // per item sideband that rides along the sqrt and divide pipelines
  typedef struct packed {
    logic               inv;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [47:0]        r2;
  } side_t;

endpackage

`default_nettype wire

// ----- src/oisl_sqrt.sv -----
// ----------------------------------------------------------------------------
// oisl_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module oisl_sqrt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [47:0]    in_rad,
  input  wire oisl_pkg::side_t in_side,
  output logic                out_valid,
  output logic [23:0]         out_root,
  output oisl_pkg::side_t     out_side
);

  localparam int Steps = 24;

  logic [47:0]     rem_q  [1:Steps];
  logic [47:0]     res_q  [1:Steps];
  oisl_pkg::side_t side_q [1:Steps];
  logic            vld_q  [1:Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [47:0] Bit = 48'(1) << (2 * (Steps - 1 - k));
    logic [47:0]     rem_in;
    logic [47:0]     res_in;
    oisl_pkg::side_t side_in;
    logic            vld_in;
    logic [47:0]     trial;

    // step input comes from the port or the previous stage
    if (k == 0) begin : g_first
      assign rem_in  = in_rad;
      assign res_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign res_in  = res_q[k];
      assign side_in = side_q[k];
      assign vld_in  = vld_q[k];
    end

    assign trial = res_in + Bit;

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_in;
      end
    end

    // one root digit per stage
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k+1] <= rem_in - trial;
          res_q[k+1] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[k+1] <= rem_in;
          res_q[k+1] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld_q[Steps];
  assign out_root  = res_q[Steps][23:0];
  assign out_side  = side_q[Steps];

endmodule

`default_nettype wire

// ----- src/oisl_div.sv -----
// ----------------------------------------------------------------------------
// oisl_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module oisl_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [57:0]     in_num,
  input  wire logic [47:0]     in_den,
  input  wire oisl_pkg::side_t in_side,
  output logic                 out_valid,
  output logic [25:0]          out_quot,
  output oisl_pkg::side_t      out_side
);

  localparam int Steps = 26;

  logic [47:0]     rem_q  [1:Steps];
  logic [25:0]     low_q  [1:Steps];
  logic [25:0]     quo_q  [1:Steps];
  logic [47:0]     den_q  [1:Steps];
  oisl_pkg::side_t side_q [1:Steps];
  logic            vld_q  [1:Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [47:0]     rem_in;
    logic [25:0]     low_in;
    logic [25:0]     quo_in;
    logic [47:0]     den_in;
    oisl_pkg::side_t side_in;
    logic            vld_in;
    logic [48:0]     trial;

    // top dividend bits, above the quotient range, seed the remainder
    if (k == 0) begin : g_first
      assign rem_in  = {16'd0, in_num[57:26]};
      assign low_in  = in_num[25:0];
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign low_in  = low_q[k];
      assign quo_in  = quo_q[k];
      assign den_in  = den_q[k];
      assign side_in = side_q[k];
      assign vld_in  = vld_q[k];
    end

    assign trial = {rem_in, low_in[25]};

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_in;
      end
    end

    // shift in the next dividend bit and try a subtract
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_in;
        den_q[k+1]  <= den_in;
        low_q[k+1]  <= {low_in[24:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_q[k+1] <= 48'(trial - {1'b0, den_in});
          quo_q[k+1] <= {quo_in[24:0], 1'b1};
        end else begin
          rem_q[k+1] <= trial[47:0];
          quo_q[k+1] <= {quo_in[24:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_q[Steps];
  assign out_quot  = quo_q[Steps];
  assign out_side  = side_q[Steps];

endmodule

`default_nettype wire

// ----- src/omni_image_to_sphere_lift_core.sv -----
// ----------------------------------------------------------------------------
// omni_image_to_sphere_lift_core
// Lifts a normalised image point of the unified camera model onto the unit
// sphere, one item per clock while the receiver does not stall.
//
// Input channel s_*: one point per item, x and y in signed Q7.16.
// Output channel m_*: sphere x, y, z in signed Q2.16 with a valid flag in
// tuser; an invalid point gives (0, 0, 1.0) with the flag low.
// cfg_wen/cfg_wdata write the mirror parameter xi (unsigned Q2.16), reset
// value 1.0; write it only while no item is in flight.
// Throughput is one item per clock while the receiver does not stall. From
// acceptance to the output register an item passes six stages for squares
// and the wide product, 24 square root stages, one stage to form the
// dividend, 26 divider stages, one scaling multiply and the output register.
// Reset empties the pipeline and restores xi to 1.0. While the receiver
// stalls with a result held, the whole pipeline holds and s_tready is low;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_image_to_sphere_lift_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [17:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // norm_x [23:0], norm_y [47:24]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // sphere_x [18:0], sphere_y [37:19], sphere_z [56:38]
  output logic             m_tuser    // valid_res [0]
);

  logic             en;
  logic [17:0]      mirror_xi;
  logic [35:0]      xi2;
  logic             dneg;
  logic [36:0]      dmag;

  // configuration register and derived 1 - xi^2
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_xi <= oisl_pkg::XiReset;
    end else if (cfg_wen) begin
      mirror_xi <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    xi2  <= mirror_xi * mirror_xi;
    dneg <= {1'b0, xi2} > {4'd0, oisl_pkg::OneQ32};
    if ({1'b0, xi2} > {4'd0, oisl_pkg::OneQ32}) begin
      dmag <= 37'({1'b0, xi2} - {4'd0, oisl_pkg::OneQ32});
    end else begin
      dmag <= 37'({4'd0, oisl_pkg::OneQ32} - {1'b0, xi2});
    end
  end

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // stage 1: magnitudes squared
  logic               v1;
  logic signed [23:0] x1, y1;
  logic [47:0]        ax2_1, ay2_1;
  logic signed [23:0] in_x, in_y;
  logic [23:0]        in_ax, in_ay;

  assign in_x  = s_tdata[23:0];
  assign in_y  = s_tdata[47:24];
  assign in_ax = in_x[23] ? 24'(-in_x) : in_x;
  assign in_ay = in_y[23] ? 24'(-in_y) : in_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= in_x;
      y1    <= in_y;
      ax2_1 <= in_ax * in_ax;
      ay2_1 <= in_ay * in_ay;
    end
  end

  // stage 2: squared radius
  logic               v2;
  logic signed [23:0] x2, y2;
  logic [47:0]        r2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= x1;
      y2   <= y1;
      r2_2 <= ax2_1 + ay2_1;
    end
  end

  // stage 3: partial products of |1 - xi^2| * r2
  logic               v3, neg3;
  logic signed [23:0] x3, y3;
  logic [47:0]        r2_3;
  logic [42:0]        pp0, pp1;
  logic [41:0]        pp2, pp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= x2;
      y3   <= y2;
      r2_3 <= r2_2;
      neg3 <= dneg;
      pp0  <= dmag[18:0] * r2_2[23:0];
      pp1  <= dmag[18:0] * r2_2[47:24];
      pp2  <= dmag[36:19] * r2_2[23:0];
      pp3  <= dmag[36:19] * r2_2[47:24];
    end
  end

  // stage 4: pair sums
  logic               v4, neg4;
  logic signed [23:0] x4, y4;
  logic [47:0]        r2_4;
  logic [61:0]        sum_a, sum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4    <= x3;
      y4    <= y3;
      r2_4  <= r2_3;
      neg4  <= neg3;
      sum_a <= {19'd0, pp0} + {1'b0, pp2, 19'd0};
      sum_b <= {19'd0, pp1} + {1'b0, pp3, 19'd0};
    end
  end

  // stage 5: full product
  logic               v5, neg5;
  logic signed [23:0] x5, y5;
  logic [47:0]        r2_5;
  logic [85:0]        prod5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5    <= x4;
      y5    <= y4;
      r2_5  <= r2_4;
      neg5  <= neg4;
      prod5 <= {24'd0, sum_a} + {sum_b, 24'd0};
    end
  end

  // stage 6: radicand and domain test
  logic            v6;
  logic [47:0]     ra6;
  oisl_pkg::side_t side6;
  logic [53:0]     p5;
  logic            frac5;

  assign p5    = prod5[85:32];
  assign frac5 = |prod5[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6.x  <= x5;
      side6.y  <= y5;
      side6.r2 <= r2_5;
      if (!neg5) begin
        side6.inv <= 1'b0;
        ra6       <= 48'({21'd0, oisl_pkg::OneQ32} + p5);
      end else begin
        side6.inv <= (p5 > 54'(oisl_pkg::OneQ32)) ||
                     ((p5 == 54'(oisl_pkg::OneQ32)) && frac5);
        ra6       <= 48'({21'd0, oisl_pkg::OneQ32} - p5 - {53'd0, frac5});
      end
    end
  end

  // square root
  logic            vs;
  logic [23:0]     root;
  oisl_pkg::side_t side_s;

  oisl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_rad    (ra6),
    .in_side   (side6),
    .out_valid (vs),
    .out_root  (root),
    .out_side  (side_s)
  );

  // dividend with half divisor for rounding, and divisor
  logic            vd;
  logic [57:0]     dnum;
  logic [47:0]     dden;
  oisl_pkg::side_t side_d;
  logic [24:0]     num_s;
  logic [47:0]     den_s;

  assign num_s = {7'd0, mirror_xi} + {1'b0, root};
  assign den_s = side_s.r2 + 48'(oisl_pkg::OneQ32);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d <= side_s;
      dden   <= den_s;
      dnum   <= {1'b0, num_s, 32'd0} + {11'd0, den_s[47:1]};
    end
  end

  // division
  logic            vq;
  logic [25:0]     fact;
  oisl_pkg::side_t side_q;

  oisl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd),
    .in_num    (dnum),
    .in_den    (dden),
    .in_side   (side_d),
    .out_valid (vq),
    .out_quot  (fact),
    .out_side  (side_q)
  );

  // scaling multiplies
  logic               vm, inv_m, sgnx_m, sgny_m;
  logic [49:0]        mx, my;
  logic signed [26:0] sz_m;
  logic [23:0]        ax_q, ay_q;

  assign ax_q = side_q.x[23] ? 24'(-side_q.x) : side_q.x;
  assign ay_q = side_q.y[23] ? 24'(-side_q.y) : side_q.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_m  <= side_q.inv;
      sgnx_m <= side_q.x[23];
      sgny_m <= side_q.y[23];
      mx     <= fact * ax_q;
      my     <= fact * ay_q;
      sz_m   <= $signed({1'b0, fact}) - $signed({9'd0, mirror_xi});
    end
  end

  // rounding, saturation and the output register
  logic [33:0]        rx, ry, cx, cy;
  logic signed [18:0] ox, oy, oz;

  assign rx = 34'((mx + 50'h8000) >> 16);
  assign ry = 34'((my + 50'h8000) >> 16);
  assign cx = (rx > oisl_pkg::OutMax) ? oisl_pkg::OutMax : rx;
  assign cy = (ry > oisl_pkg::OutMax) ? oisl_pkg::OutMax : ry;
  assign ox = sgnx_m ? 19'(-cx) : cx[18:0];
  assign oy = sgny_m ? 19'(-cy) : cy[18:0];

  always_comb begin
    if (sz_m > 27'sd131072) begin
      oz = 19'sd131072;
    end else if (sz_m < -27'sd131072) begin
      oz = -19'sd131072;
    end else begin
      oz = sz_m[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (inv_m) begin
        m_tdata <= {7'd0, oisl_pkg::InvZ, 19'd0, 19'd0};
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {7'd0, oz, oy, ox};
        m_tuser <= 1'b1;
      end
    end
  end

  // checks
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output stall");

  a_invalid_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[37:0] == 38'd0 && m_tdata[56:38] == oisl_pkg::InvZ)
    else $error("invalid point result is not (0, 0, 1)");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:57] == 7'd0)
    else $error("padding bits not zero");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[56:38]) <= 19'sd131072 &&
                 $signed(m_tdata[56:38]) >= -19'sd131072)
    else $error("sphere z out of saturation range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vm) && $stable(vq))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
